### design/fdcrc_pkg.sv
// Package for the frame deframer with CRC-16 check.
// Holds shared constants, controller/datapath command and status structs,
// and the byte-wise CRC-16/CCITT-FALSE update function. No dependencies.
package fdcrc_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] SYNC_RESET  = 8'd126;
  localparam logic [5:0] LIMIT_RESET = 6'd32;

  // Configuration register indexes.
  localparam logic REG_SYNC  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  // Input command codes.
  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_RESYNC = 1'b1;

  typedef struct packed {
    logic resync;      // clear count and check capture
    logic crc_start;   // seed the CRC with the start byte
    logic len_load;    // take the length byte
    logic data_store;  // write a payload byte and fold it into the CRC
    logic chk_clear;   // prepare for the two check bytes
    logic crc_hi_load; // capture the high check byte
    logic chk_done;    // second check byte taken
    logic err_load;    // load a mismatch report into the output register
    logic emit_start;  // rewind the payload read pointer
    logic emit_run;    // stream payload bytes to the output
  } fdcrc_cmd_t;

  typedef struct packed {
    logic sync_hit;
    logic len_ok;
    logic last_data;
    logic crc_second;
    logic crc_match;
    logic out_busy;
    logic emit_done;
  } fdcrc_stat_t;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### design/fdcrc_in_if.sv
// Input channel of the frame deframer: valid/ready plus command and byte.
// Depends on nothing.
interface fdcrc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, cmd, data_byte, input ready);
  modport sink   (input valid, cmd, data_byte, output ready);
endinterface

### design/fdcrc_out_if.sv
// Result channel of the frame deframer: valid/ready plus the result fields.
// Depends on nothing.
interface fdcrc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        frame_ok;
  logic        last;
  logic [5:0]  frame_length;
  logic [15:0] computed_crc;
  logic [15:0] received_check;

  modport source (output valid, payload_byte, frame_ok, last, frame_length,
                  computed_crc, received_check, input ready);
  modport sink   (input valid, payload_byte, frame_ok, last, frame_length,
                  computed_crc, received_check, output ready);
endinterface

### design/frame_deframer_crc16.sv
// Top level of the length-prefixed frame deframer with CRC-16/CCITT-FALSE.
// Instantiates fdcrc_ctrl and fdcrc_dpath; uses fdcrc_pkg, fdcrc_in_if, fdcrc_out_if.
//
//   channel   dir   handshake      item contents
//   in_ch     in    valid/ready    cmd, data_byte
//   out_ch    out   valid/ready    payload_byte, frame_ok, last, frame_length,
//                                  computed_crc, received_check
//   cfg       in    cfg_we only    cfg_index, cfg_data (sync_byte, length_limit)
//
// While hunting or parsing a frame, one input item is taken every cycle; the
// CRC folds in one byte per cycle through an eight-step shift network.
// After a good frame's second check byte, input is held off while the payload
// memory drains at one item per cycle (its single registered read port sets
// this) whenever the result register is free, until the last byte is loaded.
// Result items wait in an output register; a stalled result holds input off
// only at the second check byte of a frame, until the register is free.
// Reset (rst, synchronous) restores the config defaults and returns to hunting.
module frame_deframer_crc16 #(
  parameter int MAX_PAYLOAD = fdcrc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst,
  fdcrc_in_if.sink          in_ch,
  fdcrc_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data
);

  // The controller sees only status from the datapath and sends commands back.
  fdcrc_pkg::fdcrc_cmd_t  cmd;
  fdcrc_pkg::fdcrc_stat_t stat;

  fdcrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath owns the config registers, CRC, payload memory and the
  // result register that drives the output channel.
  fdcrc_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .data_byte          (in_ch.data_byte),
    .cmd                (cmd),
    .stat               (stat),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_payload_byte   (out_ch.payload_byte),
    .out_frame_ok       (out_ch.frame_ok),
    .out_last           (out_ch.last),
    .out_frame_length   (out_ch.frame_length),
    .out_computed_crc   (out_ch.computed_crc),
    .out_received_check (out_ch.received_check)
  );

endmodule

### design/fdcrc_dpath.sv
// Datapath of the frame deframer: config registers, CRC accumulator,
// payload memory with registered read, and the result register. Uses fdcrc_pkg.
module fdcrc_dpath #(
  parameter int MAX_PAYLOAD = fdcrc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic [7:0]           data_byte,
  input  fdcrc_pkg::fdcrc_cmd_t  cmd,
  output fdcrc_pkg::fdcrc_stat_t stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [7:0]           out_payload_byte,
  output logic                 out_frame_ok,
  output logic                 out_last,
  output logic [5:0]           out_frame_length,
  output logic [15:0]          out_computed_crc,
  output logic [15:0]          out_received_check
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [6:0] MAX_LEN = 7'(MAX_PAYLOAD);

  logic [7:0]  sync_byte;
  logic [5:0]  length_limit;
  logic [5:0]  frame_len;
  logic [5:0]  byte_count;
  logic [15:0] crc_acc;
  logic [7:0]  crc_high;
  logic        crc_second;
  logic [15:0] rx_crc;

  logic [7:0]  mem [MAX_PAYLOAD];
  logic [5:0]  rd_idx;
  logic [7:0]  ram_q;
  logic        ram_q_last;
  logic        qv;

  logic [6:0]  lim;
  logic [5:0]  count_inc;
  logic [15:0] rx_word;
  logic        more;
  logic        out_take;
  logic        load_out;
  logic        issue;

  assign lim       = ({1'b0, length_limit} > MAX_LEN) ? MAX_LEN : {1'b0, length_limit};
  assign count_inc = byte_count + 6'd1;
  assign rx_word   = {crc_high, data_byte};
  assign more      = rd_idx < frame_len;
  assign out_take  = out_valid & out_ready;
  assign load_out  = qv & (~out_valid | out_take);
  assign issue     = cmd.emit_run & more & (~qv | load_out);

  always_comb begin
    stat.sync_hit   = data_byte == sync_byte;
    stat.len_ok     = (data_byte != 8'd0) && (data_byte <= {1'b0, lim});
    stat.last_data  = count_inc >= frame_len;
    stat.crc_second = crc_second;
    stat.crc_match  = rx_word == crc_acc;
    stat.out_busy   = out_valid;
    stat.emit_done  = ~more & ~qv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte    <= fdcrc_pkg::SYNC_RESET;
      length_limit <= fdcrc_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fdcrc_pkg::REG_SYNC:  sync_byte    <= cfg_data;
        fdcrc_pkg::REG_LIMIT: length_limit <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_len  <= 6'd0;
      byte_count <= 6'd0;
      crc_acc    <= fdcrc_pkg::CRC_INIT;
      crc_high   <= 8'd0;
      crc_second <= 1'b0;
    end else begin
      if (cmd.crc_start) begin
        crc_acc <= fdcrc_pkg::crc16_update(fdcrc_pkg::CRC_INIT, data_byte);
      end
      if (cmd.len_load) begin
        frame_len  <= data_byte[5:0];
        byte_count <= 6'd0;
        crc_acc    <= fdcrc_pkg::crc16_update(crc_acc, data_byte);
      end
      if (cmd.data_store) begin
        crc_acc    <= fdcrc_pkg::crc16_update(crc_acc, data_byte);
        byte_count <= count_inc;
      end
      if (cmd.crc_hi_load) begin
        crc_high   <= data_byte;
        crc_second <= 1'b1;
      end
      if (cmd.chk_done) begin
        crc_second <= 1'b0;
      end
      if (cmd.chk_clear) begin
        crc_high   <= 8'd0;
        crc_second <= 1'b0;
      end
      if (cmd.resync) begin
        byte_count <= 6'd0;
        crc_high   <= 8'd0;
        crc_second <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chk_done) begin
      rx_crc <= rx_word;
    end
  end

  // Payload store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.data_store) begin
      mem[byte_count[AW-1:0]] <= data_byte;
    end
    if (issue) begin
      ram_q      <= mem[rd_idx[AW-1:0]];
      ram_q_last <= ({1'b0, rd_idx} + 7'd1) == {1'b0, frame_len};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= 6'd0;
      qv     <= 1'b0;
    end else begin
      if (cmd.emit_start) begin
        rd_idx <= 6'd0;
      end else if (issue) begin
        rd_idx <= rd_idx + 6'd1;
      end
      qv <= issue | (qv & ~load_out);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out || cmd.err_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_load) begin
      out_payload_byte   <= 8'd0;
      out_frame_ok       <= 1'b0;
      out_last           <= 1'b1;
      out_frame_length   <= frame_len;
      out_computed_crc   <= crc_acc;
      out_received_check <= rx_word;
    end else if (load_out) begin
      out_payload_byte   <= ram_q;
      out_frame_ok       <= 1'b1;
      out_last           <= ram_q_last;
      out_frame_length   <= frame_len;
      out_computed_crc   <= crc_acc;
      out_received_check <= rx_crc;
    end
  end

endmodule

### design/fdcrc_ctrl.sv
// Controller of the frame deframer: the parse state machine and input ready.
// Drives datapath commands from datapath status. Uses fdcrc_pkg.
module fdcrc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_cmd,
  output logic                   in_ready,
  input  fdcrc_pkg::fdcrc_stat_t stat,
  output fdcrc_pkg::fdcrc_cmd_t  cmd
);

  localparam logic [2:0] ST_HUNT  = 3'd0;
  localparam logic [2:0] ST_LEN   = 3'd1;
  localparam logic [2:0] ST_DATA  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       acc;

  // A mismatch report needs the result register free on the last check byte.
  assign in_ready = (state != ST_EMIT) &&
                    !((state == ST_CHECK) && stat.crc_second && stat.out_busy);
  assign acc = in_valid & in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    if (state == ST_EMIT) begin
      cmd.emit_run = 1'b1;
      if (stat.emit_done) begin
        state_next = ST_HUNT;
      end
    end else if (acc && (in_cmd == fdcrc_pkg::CMD_RESYNC)) begin
      cmd.resync = 1'b1;
      state_next = ST_HUNT;
    end else if (acc) begin
      unique case (state)
        ST_HUNT: begin
          if (stat.sync_hit) begin
            cmd.crc_start = 1'b1;
            state_next    = ST_LEN;
          end
        end
        ST_LEN: begin
          if (stat.len_ok) begin
            cmd.len_load = 1'b1;
            state_next   = ST_DATA;
          end else begin
            state_next = ST_HUNT;
          end
        end
        ST_DATA: begin
          cmd.data_store = 1'b1;
          if (stat.last_data) begin
            cmd.chk_clear = 1'b1;
            state_next    = ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!stat.crc_second) begin
            cmd.crc_hi_load = 1'b1;
          end else if (stat.crc_match) begin
            cmd.chk_done   = 1'b1;
            cmd.emit_start = 1'b1;
            state_next     = ST_EMIT;
          end else begin
            cmd.chk_done = 1'b1;
            cmd.err_load = 1'b1;
            state_next   = ST_HUNT;
          end
        end
        default: state_next = ST_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/fdcrc_checker.sv
// Port-level checker for frame_deframer_crc16, attached with a bind.
// Depends only on the top level's ports.
module fdcrc_assert (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  payload_byte,
  input logic        frame_ok,
  input logic        last,
  input logic [5:0]  frame_length,
  input logic [15:0] computed_crc,
  input logic [15:0] received_check
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(last))
    else $error("result changed while stalled");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_ok |-> last && payload_byte == 8'd0 &&
                               computed_crc != received_check)
    else $error("mismatch report malformed");

  a_good_crc: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_ok |-> computed_crc == received_check && frame_length != 6'd0)
    else $error("good frame byte with failed check");

  a_same_frame: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && out_ready && frame_ok && !last) && out_valid |->
      frame_ok && frame_length == $past(frame_length))
    else $error("frame interrupted before its last byte");

endmodule

bind frame_deframer_crc16 fdcrc_assert u_fdcrc_assert (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .payload_byte   (out_ch.payload_byte),
  .frame_ok       (out_ch.frame_ok),
  .last           (out_ch.last),
  .frame_length   (out_ch.frame_length),
  .computed_crc   (out_ch.computed_crc),
  .received_check (out_ch.received_check)
);
